// File: design/fcse_pkg.sv
package fcse_pkg;

  localparam int TEMP_W      = 8;
  localparam int DUTY_W      = 8;
  localparam int CHAN_W      = 2;
  localparam int SLOPE_W     = 12;
  localparam int SCALE_SHIFT = 4;                          // slope scale of 16
  localparam int NUM_W       = DUTY_W + SCALE_SHIFT + 1;   // scaled diff plus half divisor
  localparam int REM_W       = TEMP_W;
  localparam int WORK_W      = REM_W + NUM_W;
  localparam int LANES       = 3;

  typedef enum logic [1:0] {
    STATUS_ENCODED = 2'd0,
    STATUS_SKIPPED = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  // per-segment divider lane: divisor plus {remainder, numerator/quotient} word
  typedef struct packed {
    logic [TEMP_W-1:0] dt;
    logic [WORK_W-1:0] work;
  } lane_t;

  // fields that ride alongside the divider untouched
  typedef struct packed {
    status_t           status;
    logic [CHAN_W-1:0] chan;
    logic [TEMP_W-1:0] temp_a;
    logic [DUTY_W-1:0] duty_a;
    logic [TEMP_W-1:0] temp_b;
    logic [DUTY_W-1:0] duty_b;
  } meta_t;

  // one restoring division step: remainder takes the next numerator bit,
  // quotient bit shifts in at the bottom
  function automatic logic [WORK_W-1:0] div_step(input logic [WORK_W-1:0] w,
                                                 input logic [TEMP_W-1:0] dt);
    logic [REM_W:0]   sh;
    logic [NUM_W-1:0] nb;
    logic [REM_W-1:0] rem;
    sh  = {w[WORK_W-1 -: REM_W], w[NUM_W-1]};
    nb  = {w[NUM_W-2:0], 1'b0};
    rem = sh[REM_W-1:0];
    if (sh >= {1'b0, dt}) begin
      rem   = REM_W'(sh - {1'b0, dt});
      nb[0] = 1'b1;
    end
    return {rem, nb};
  endfunction

endpackage

// File: design/fan_curve_slope_encoder_unit.sv
// fan curve slope encoder
// input channel: in_valid/in_ready with one fan's four-point curve (four
// temperatures, four raw duty bytes) and the fan channel
// output channel: out_valid/out_ready with the status, the echoed channel,
// points two and three, and the three rounded sixteenfold segment slopes
// a curve of all zeros reports skipped, non-rising temperatures report
// invalid; both give zero points and slopes
// throughput: one transaction per cycle while out_ready is held high; the
// slopes come from three restoring dividers laid out as a pipeline,
// STEPS_PER_STAGE quotient bits per stage
// an accepted curve passes the prep stage register and then each divider
// stage register, and the last of these drives out_valid
// each stage holds its data while the stage after it is full and stalled;
// empty stages keep filling, so in_ready only drops once every stage is full
// and the receiver holds out_ready low
// reset (rst_n low, synchronous) empties the pipeline; no result is lost or
// repeated across a stall
module fan_curve_slope_encoder_unit #(
  parameter int STEPS_PER_STAGE = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fcse_pkg::CHAN_W-1:0]  in_fan_channel,
  input  logic [fcse_pkg::TEMP_W-1:0]  in_temp_point0,
  input  logic [fcse_pkg::TEMP_W-1:0]  in_temp_point1,
  input  logic [fcse_pkg::TEMP_W-1:0]  in_temp_point2,
  input  logic [fcse_pkg::TEMP_W-1:0]  in_temp_point3,
  input  logic [fcse_pkg::DUTY_W-1:0]  in_duty_point0,
  input  logic [fcse_pkg::DUTY_W-1:0]  in_duty_point1,
  input  logic [fcse_pkg::DUTY_W-1:0]  in_duty_point2,
  input  logic [fcse_pkg::DUTY_W-1:0]  in_duty_point3,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [fcse_pkg::CHAN_W-1:0]  out_channel_echo,
  output logic [fcse_pkg::TEMP_W-1:0]  out_sent_temp_a,
  output logic [fcse_pkg::DUTY_W-1:0]  out_sent_duty_a,
  output logic [fcse_pkg::TEMP_W-1:0]  out_sent_temp_b,
  output logic [fcse_pkg::DUTY_W-1:0]  out_sent_duty_b,
  output logic [fcse_pkg::SLOPE_W-1:0] out_slope_first,
  output logic [fcse_pkg::SLOPE_W-1:0] out_slope_second,
  output logic [fcse_pkg::SLOPE_W-1:0] out_slope_third
);
  import fcse_pkg::*;

  // number of divider stages after the prep stage
  localparam int NSTG = (NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // stage 0 is prep, stages 1..NSTG run the dividers, stage NSTG drives the outputs
  logic              valid_r [0:NSTG];
  meta_t             meta_r  [0:NSTG];
  lane_t             lane_r  [0:NSTG][0:LANES-1];
  logic [NSTG:0]     rdy;

  meta_t             meta_nxt;
  lane_t             lane_nxt [0:LANES-1];

  // a stage may load when it is empty or its contents move on this cycle
  always_comb begin
    rdy[NSTG] = !valid_r[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  // prep: classify the curve and form dividend and divisor per segment
  always_comb begin
    logic [TEMP_W-1:0] t [0:3];
    logic [DUTY_W-1:0] d [0:3];
    logic              all_zero;
    logic              rising;
    logic              encode;
    t = '{in_temp_point0, in_temp_point1, in_temp_point2, in_temp_point3};
    d = '{in_duty_point0, in_duty_point1, in_duty_point2, in_duty_point3};
    all_zero = 1'b1;
    rising   = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (t[i] != '0 || d[i] != '0) all_zero = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      if (t[i+1] <= t[i]) rising = 1'b0;
    end
    encode = !all_zero && rising;

    meta_nxt.chan   = in_fan_channel;
    meta_nxt.status = all_zero ? STATUS_SKIPPED : (rising ? STATUS_ENCODED : STATUS_INVALID);
    meta_nxt.temp_a = encode ? t[1] : '0;
    meta_nxt.duty_a = encode ? d[1] : '0;
    meta_nxt.temp_b = encode ? t[2] : '0;
    meta_nxt.duty_b = encode ? d[2] : '0;

    for (int i = 0; i < LANES; i++) begin
      // falling or flat duty clamps to zero; a dead curve divides 0 by 1
      if (encode) begin
        lane_nxt[i].dt = TEMP_W'(t[i+1] - t[i]);
      end else begin
        lane_nxt[i].dt = TEMP_W'(1);
      end
      if (encode && d[i+1] > d[i]) begin
        lane_nxt[i].work = {{REM_W{1'b0}},
          NUM_W'({DUTY_W'(d[i+1] - d[i]), {SCALE_SHIFT{1'b0}}})
          + NUM_W'(lane_nxt[i].dt >> 1)};
      end else begin
        lane_nxt[i].work = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      valid_r[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      meta_r[0] <= meta_nxt;
      lane_r[0] <= lane_nxt;
    end
  end

  // divider stages, each a slice of the restoring division
  for (genvar k = 1; k <= NSTG; k++) begin : g_div
    localparam int FIRST = (k - 1) * STEPS_PER_STAGE;
    lane_t work_nxt [0:LANES-1];

    always_comb begin
      logic [WORK_W-1:0] w;
      for (int l = 0; l < LANES; l++) begin
        w = lane_r[k-1][l].work;
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
          if (FIRST + j < NUM_W) w = div_step(w, lane_r[k-1][l].dt);
        end
        work_nxt[l].dt   = lane_r[k-1][l].dt;
        work_nxt[l].work = w;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_r[k] <= valid_r[k-1];
      end
      if (rdy[k] && valid_r[k-1]) begin
        meta_r[k] <= meta_r[k-1];
        lane_r[k] <= work_nxt;
      end
    end
  end

  // outputs straight from the last stage; quotient sits in the low bits
  assign out_valid        = valid_r[NSTG];
  assign out_status       = meta_r[NSTG].status;
  assign out_channel_echo = meta_r[NSTG].chan;
  assign out_sent_temp_a  = meta_r[NSTG].temp_a;
  assign out_sent_duty_a  = meta_r[NSTG].duty_a;
  assign out_sent_temp_b  = meta_r[NSTG].temp_b;
  assign out_sent_duty_b  = meta_r[NSTG].duty_b;
  assign out_slope_first  = lane_r[NSTG][0].work[SLOPE_W-1:0];
  assign out_slope_second = lane_r[NSTG][1].work[SLOPE_W-1:0];
  assign out_slope_third  = lane_r[NSTG][2].work[SLOPE_W-1:0];

`ifndef SYNTHESIS
  // an accepted transaction lands in the prep stage
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> valid_r[0])
    else $error("accepted transaction missing from prep stage");

  // an empty output stage never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[NSTG] |-> in_ready)
    else $error("input stalled with empty output stage");

  // skipped or invalid curves carry zero slopes
  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_ENCODED) |->
      (out_slope_first == '0 && out_slope_second == '0 && out_slope_third == '0
       && out_sent_temp_a == '0 && out_sent_temp_b == '0))
    else $error("non-encoded result with nonzero payload");

  // quotient never spills past the slope field
  a_slope_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (lane_r[NSTG][0].work[NUM_W-1:SLOPE_W] == '0
                   && lane_r[NSTG][1].work[NUM_W-1:SLOPE_W] == '0
                   && lane_r[NSTG][2].work[NUM_W-1:SLOPE_W] == '0))
    else $error("slope quotient overflow");
`endif

endmodule

// File: bench/fan_curve_slope_encoder_unit_tb.sv
module fan_curve_slope_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcse_pkg::*;

  // run shape
  localparam int RANDOM_CURVES  = 1250;
  localparam int CALM_CURVES    = 150;   // tail with no idling on either side
  localparam int DRAIN_CYCLES   = 20;    // allow plenty beyond the pipeline latency
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction on either side
  localparam int REPORT_LIMIT   = 10;
  localparam int DIRECTED_ROWS  = 20;

  // one fan curve as it enters the block
  typedef struct packed {
    logic [CHAN_W-1:0]            chan;
    logic [3:0][TEMP_W-1:0]       temp;
    logic [3:0][DUTY_W-1:0]       duty;
  } curve_t;

  // one encoded curve as it leaves the block
  typedef struct packed {
    status_t                      status;
    logic [CHAN_W-1:0]            chan;
    logic [TEMP_W-1:0]            temp_a;
    logic [DUTY_W-1:0]            duty_a;
    logic [TEMP_W-1:0]            temp_b;
    logic [DUTY_W-1:0]            duty_b;
    logic [2:0][SLOPE_W-1:0]      slope;
  } encoding_t;

  // directed row: curve plus, where obvious, the hand-worked encoding
  typedef struct packed {
    curve_t                       curve;
    logic                         hand_checked;
    encoding_t                    encoding;
  } curve_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAN_W-1:0] in_fan_channel = '0;
  logic [TEMP_W-1:0] in_temp_point0 = '0;
  logic [TEMP_W-1:0] in_temp_point1 = '0;
  logic [TEMP_W-1:0] in_temp_point2 = '0;
  logic [TEMP_W-1:0] in_temp_point3 = '0;
  logic [DUTY_W-1:0] in_duty_point0 = '0;
  logic [DUTY_W-1:0] in_duty_point1 = '0;
  logic [DUTY_W-1:0] in_duty_point2 = '0;
  logic [DUTY_W-1:0] in_duty_point3 = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [CHAN_W-1:0] out_channel_echo;
  logic [TEMP_W-1:0] out_sent_temp_a;
  logic [DUTY_W-1:0] out_sent_duty_a;
  logic [TEMP_W-1:0] out_sent_temp_b;
  logic [DUTY_W-1:0] out_sent_duty_b;
  logic [SLOPE_W-1:0] out_slope_first;
  logic [SLOPE_W-1:0] out_slope_second;
  logic [SLOPE_W-1:0] out_slope_third;

  // encodings still owed by the block, oldest first
  encoding_t pending_encodings[$];

  int  mismatches = 0;
  int  encodings_checked = 0;
  int  encoded_curves = 0;
  int  skipped_curves = 0;
  int  invalid_curves = 0;
  int  quiet_cycles = 0;
  bit  calm_tail = 1'b0;

  fan_curve_slope_encoder_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_fan_channel   (in_fan_channel),
    .in_temp_point0   (in_temp_point0),
    .in_temp_point1   (in_temp_point1),
    .in_temp_point2   (in_temp_point2),
    .in_temp_point3   (in_temp_point3),
    .in_duty_point0   (in_duty_point0),
    .in_duty_point1   (in_duty_point1),
    .in_duty_point2   (in_duty_point2),
    .in_duty_point3   (in_duty_point3),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_channel_echo (out_channel_echo),
    .out_sent_temp_a  (out_sent_temp_a),
    .out_sent_duty_a  (out_sent_duty_a),
    .out_sent_temp_b  (out_sent_temp_b),
    .out_sent_duty_b  (out_sent_duty_b),
    .out_slope_first  (out_slope_first),
    .out_slope_second (out_slope_second),
    .out_slope_third  (out_slope_third)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic curve_t mk_curve(input int unsigned chan,
                                      input int unsigned t0, input int unsigned t1,
                                      input int unsigned t2, input int unsigned t3,
                                      input int unsigned d0, input int unsigned d1,
                                      input int unsigned d2, input int unsigned d3);
    curve_t c;
    c.chan = CHAN_W'(chan);
    c.temp = {TEMP_W'(t3), TEMP_W'(t2), TEMP_W'(t1), TEMP_W'(t0)};
    c.duty = {DUTY_W'(d3), DUTY_W'(d2), DUTY_W'(d1), DUTY_W'(d0)};
    return c;
  endfunction

  function automatic encoding_t mk_encoding(input status_t status, input int unsigned chan,
                                            input int unsigned ta, input int unsigned da,
                                            input int unsigned tb, input int unsigned db,
                                            input int unsigned s0, input int unsigned s1,
                                            input int unsigned s2);
    encoding_t e;
    e.status = status;
    e.chan   = CHAN_W'(chan);
    e.temp_a = TEMP_W'(ta);
    e.duty_a = DUTY_W'(da);
    e.temp_b = TEMP_W'(tb);
    e.duty_b = DUTY_W'(db);
    e.slope  = {SLOPE_W'(s2), SLOPE_W'(s1), SLOPE_W'(s0)};
    return e;
  endfunction

  // predictor: all-zero curve is skipped, non-rising temperatures are invalid,
  // otherwise points two and three pass and each segment gets
  // round-half-up(rise * 16 / run), falling or flat segments clamp to zero
  function automatic encoding_t encode_curve(input curve_t c);
    encoding_t   e;
    bit          ascending;
    int unsigned rise;
    int unsigned run;
    e = '0;
    e.chan = c.chan;
    ascending = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (c.temp[i+1] <= c.temp[i]) ascending = 1'b0;
    end
    if (c.temp == '0 && c.duty == '0) begin
      e.status = STATUS_SKIPPED;
    end else if (!ascending) begin
      e.status = STATUS_INVALID;
    end else begin
      e.status = STATUS_ENCODED;
      e.temp_a = c.temp[1];
      e.duty_a = c.duty[1];
      e.temp_b = c.temp[2];
      e.duty_b = c.duty[2];
      for (int i = 0; i < 3; i++) begin
        if (c.duty[i+1] > c.duty[i]) begin
          rise = (int'(c.duty[i+1]) - int'(c.duty[i])) << SCALE_SHIFT;
          run  = int'(c.temp[i+1]) - int'(c.temp[i]);
          e.slope[i] = SLOPE_W'((rise + run / 2) / run);
        end
      end
    end
    return e;
  endfunction

  // directed curves: extremes, every status, every channel code, rounding edges
  curve_row_t directed_rows [DIRECTED_ROWS] = '{
    // all-zero curve, skipped
    '{mk_curve(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      mk_encoding(STATUS_SKIPPED, 0, 0, 0, 0, 0, 0, 0, 0)},
    // all-zero curve on the top channel code
    '{mk_curve(3, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      mk_encoding(STATUS_SKIPPED, 3, 0, 0, 0, 0, 0, 0, 0)},
    // every field at its top, flat temperatures
    '{mk_curve(3, 255, 255, 255, 255, 255, 255, 255, 255), 1'b1,
      mk_encoding(STATUS_INVALID, 3, 0, 0, 0, 0, 0, 0, 0)},
    // one equal pair in the middle
    '{mk_curve(2, 10, 20, 20, 30, 40, 50, 60, 70), 1'b1,
      mk_encoding(STATUS_INVALID, 2, 0, 0, 0, 0, 0, 0, 0)},
    // falling temperatures
    '{mk_curve(1, 255, 200, 100, 0, 1, 2, 3, 4), 1'b1,
      mk_encoding(STATUS_INVALID, 1, 0, 0, 0, 0, 0, 0, 0)},
    // duty alone non-zero with zero temperatures
    '{mk_curve(0, 0, 0, 0, 0, 1, 0, 0, 0), 1'b1,
      mk_encoding(STATUS_INVALID, 0, 0, 0, 0, 0, 0, 0, 0)},
    // last temperature alone non-zero
    '{mk_curve(1, 0, 0, 0, 1, 0, 0, 0, 0), 1'b1,
      mk_encoding(STATUS_INVALID, 1, 0, 0, 0, 0, 0, 0, 0)},
    // steepest possible rise, and a full drop clamped to zero
    '{mk_curve(2, 0, 1, 2, 3, 0, 255, 0, 255), 1'b1,
      mk_encoding(STATUS_ENCODED, 2, 1, 255, 2, 0, 4080, 0, 4080)},
    // top temperatures, flat duty
    '{mk_curve(0, 252, 253, 254, 255, 255, 255, 255, 255), 1'b1,
      mk_encoding(STATUS_ENCODED, 0, 253, 255, 254, 255, 0, 0, 0)},
    // widest segments, unit slope
    '{mk_curve(1, 0, 85, 170, 255, 0, 85, 170, 255), 1'b1,
      mk_encoding(STATUS_ENCODED, 1, 85, 85, 170, 170, 16, 16, 16)},
    // exact half rounds up
    '{mk_curve(0, 0, 32, 64, 96, 0, 1, 2, 3), 1'b0, '0},
    // just under a half rounds down
    '{mk_curve(1, 0, 33, 66, 99, 0, 1, 2, 3), 1'b0, '0},
    '{mk_curve(2, 0, 3, 6, 9, 0, 1, 3, 8), 1'b0, '0},
    '{mk_curve(3, 10, 20, 30, 40, 50, 60, 40, 200), 1'b0, '0},
    // alternating up and down
    '{mk_curve(0, 5, 6, 7, 8, 255, 0, 255, 0), 1'b0, '0},
    '{mk_curve(1, 0, 1, 254, 255, 0, 255, 255, 255), 1'b0, '0},
    // rising temperatures with all-zero duty is not skipped
    '{mk_curve(2, 1, 2, 3, 4, 0, 0, 0, 0), 1'b0, '0},
    '{mk_curve(3, 100, 101, 102, 103, 7, 200, 201, 254), 1'b0, '0},
    '{mk_curve(0, 0, 254, 255, 255, 0, 255, 0, 0), 1'b0, '0},
    '{mk_curve(2, 17, 64, 128, 191, 170, 171, 85, 240), 1'b0, '0}
  };

  // sender: optional idle burst, then hold the curve until it is taken
  task automatic offer_curve(input curve_t c, input bit hand_checked, input encoding_t hand);
    int unsigned gap;
    encoding_t   due;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_fan_channel = c.chan;
    in_temp_point0 = c.temp[0];
    in_temp_point1 = c.temp[1];
    in_temp_point2 = c.temp[2];
    in_temp_point3 = c.temp[3];
    in_duty_point0 = c.duty[0];
    in_duty_point1 = c.duty[1];
    in_duty_point2 = c.duty[2];
    in_duty_point3 = c.duty[3];
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    // transaction accepted at this edge
    due = hand_checked ? hand : encode_curve(c);
    case (due.status)
      STATUS_ENCODED: encoded_curves++;
      STATUS_SKIPPED: skipped_curves++;
      default:        invalid_curves++;
    endcase
    pending_encodings.push_back(due);
  endtask

  // receiver: random stall bursts, steady ready in the tail
  initial begin
    int unsigned span;
    forever begin
      if (!calm_tail && $urandom_range(0, 2) == 0) begin
        span = $urandom_range(1, 11);
        @(negedge clk);
        out_ready = 1'b0;
      end else begin
        span = $urandom_range(1, 20);
        @(negedge clk);
        out_ready = 1'b1;
      end
      repeat (span - 1) @(negedge clk);
    end
  end

  // result checker: each output transaction against the oldest owed encoding
  always @(posedge clk) begin
    encoding_t seen;
    encoding_t due;
    if (rst_n && out_valid && out_ready) begin
      seen.status = status_t'(out_status);
      seen.chan   = out_channel_echo;
      seen.temp_a = out_sent_temp_a;
      seen.duty_a = out_sent_duty_a;
      seen.temp_b = out_sent_temp_b;
      seen.duty_b = out_sent_duty_b;
      seen.slope  = {out_slope_third, out_slope_second, out_slope_first};
      if (pending_encodings.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected transaction, status %0d chan %0d", $realtime,
                   out_status, out_channel_echo);
      end else begin
        due = pending_encodings.pop_front();
        encodings_checked++;
        if (seen.status !== due.status || seen.chan !== due.chan ||
            seen.temp_a !== due.temp_a || seen.duty_a !== due.duty_a ||
            seen.temp_b !== due.temp_b || seen.duty_b !== due.duty_b ||
            seen.slope[0] !== due.slope[0] || seen.slope[1] !== due.slope[1] ||
            seen.slope[2] !== due.slope[2]) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: mismatch on transaction %0d", $realtime, encodings_checked);
            $display("  expected status %0d chan %0d a %0d/%0d b %0d/%0d slopes %0d %0d %0d",
                     due.status, due.chan, due.temp_a, due.duty_a, due.temp_b,
                     due.duty_b, due.slope[0], due.slope[1], due.slope[2]);
            $display("  actual   status %0d chan %0d a %0d/%0d b %0d/%0d slopes %0d %0d %0d",
                     seen.status, seen.chan, seen.temp_a, seen.duty_a, seen.temp_b,
                     seen.duty_b, seen.slope[0], seen.slope[1], seen.slope[2]);
          end
        end
      end
    end
  end

  // watchdog: too long with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d encodings outstanding",
                 pending_encodings.size());
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    curve_t      c;
    int unsigned roll;
    int unsigned g1;
    int unsigned g2;
    int unsigned g3;
    int unsigned pick;

    // reset, released away from the clock edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++)
      offer_curve(directed_rows[r].curve, directed_rows[r].hand_checked,
                  directed_rows[r].encoding);

    // random curves, mostly well-formed rising ones
    for (int k = 0; k < RANDOM_CURVES; k++) begin
      // hold off once until the pipeline has fully drained
      if (k == RANDOM_CURVES / 2) begin
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_encodings.size() != 0) @(posedge clk);
      end
      if (k == RANDOM_CURVES - CALM_CURVES) calm_tail = 1'b1;

      c.chan = CHAN_W'($urandom_range(0, 3));
      c.duty = $urandom;
      roll   = $urandom_range(0, 99);
      if (roll < 70) begin
        if (roll < 30) begin
          // tight spacing for large slopes and awkward rounding
          g1 = $urandom_range(1, 4);
          g2 = $urandom_range(1, 4);
          g3 = $urandom_range(1, 4);
          c.temp[0] = TEMP_W'($urandom_range(0, 255 - g1 - g2 - g3));
          c.temp[1] = c.temp[0] + TEMP_W'(g1);
          c.temp[2] = c.temp[1] + TEMP_W'(g2);
          c.temp[3] = c.temp[2] + TEMP_W'(g3);
        end else begin
          c.temp[0] = TEMP_W'($urandom_range(0, 252));
          c.temp[1] = TEMP_W'($urandom_range(int'(c.temp[0]) + 1, 253));
          c.temp[2] = TEMP_W'($urandom_range(int'(c.temp[1]) + 1, 254));
          c.temp[3] = TEMP_W'($urandom_range(int'(c.temp[2]) + 1, 255));
        end
        // some flat duty stretches
        if (roll < 8) c.duty[2] = c.duty[1];
      end else if (roll < 80) begin
        // zero curves, some with a single stray byte
        c.temp = '0;
        c.duty = '0;
        if (roll >= 75) begin
          pick = $urandom_range(0, 7);
          if (pick < 4) c.temp[pick] = TEMP_W'($urandom_range(1, 255));
          else c.duty[pick - 4] = DUTY_W'($urandom_range(1, 255));
        end
      end else begin
        // noise, mostly non-rising
        c.temp = $urandom;
      end
      offer_curve(c, 1'b0, '0);
    end

    @(negedge clk);
    in_valid = 1'b0;

    // drain, then give any stray extra transaction time to show up
    while (pending_encodings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d encodings: %0d encoded, %0d skipped, %0d invalid curves",
             encodings_checked, encoded_curves, skipped_curves, invalid_curves);
    $display("with random sender gaps and receiver stalls, one full drain, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
